>>> rtl/hsv2rgb_pkg.sv
// types, constants and sector codes for the hsv to rgb converter
package hsv2rgb_pkg;

    localparam int unsigned HUE_W  = 9;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned CHAN_W = 8;

    localparam int unsigned HUE_MAX    = 360;
    localparam int unsigned PCT_MAX    = 100;
    localparam int unsigned SECTOR_DEG = 60;

    // product s*v and 100*v, each at most 10000
    localparam int unsigned PROD_W = 14;
    // triangle weight, at most 60
    localparam int unsigned TRI_W  = 6;
    // numerators over 600000, at most 600000
    localparam int unsigned NUM_W  = 20;
    localparam int unsigned DENOM  = 600000;

    // floor(255 * n / 600000) = floor(17 * n / 40000) by reciprocal multiply
    localparam int unsigned DIV_DEN   = DENOM / 15;
    localparam int unsigned DIV_SHIFT = 40;
    localparam longint unsigned RECIP_BASE =
        ((64'd1 << DIV_SHIFT) + 64'(DIV_DEN) - 64'd1) / 64'(DIV_DEN);
    localparam int unsigned MUL_W  = 29;
    localparam logic [MUL_W-1:0] CHAN_MUL = MUL_W'(RECIP_BASE * 64'd17);
    localparam int unsigned PRODUCT_W = NUM_W + MUL_W;

    localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;
    localparam logic [2:0] SEC_BLUE_RED   = 3'd4;
    localparam logic [2:0] SEC_RED_BLUE   = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] saturation;
        logic [PCT_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              range_error;
    } t_rgb;

endpackage

>>> rtl/hsv_to_rgb_converter.sv
// hsv to rgb converter: five stage pipeline from hsv pixel to 8-bit rgb
//
// Input channel: i_valid, o_stall, i_pixel (hue 0-360, saturation and
// brightness 0-100). A beat is taken when i_valid is high and o_stall low.
// Output channel: o_valid, i_stall, o_pixel (red, green, blue, range_error).
// A beat leaves when o_valid is high and i_stall low.
// Out-of-range inputs give zero channels with range_error set.
// Throughput is one pixel per cycle while o_stall is low. The stages are:
// range check and sector decode, s*v and 100*v, chroma/secondary/offset
// products, sector routing and add, and the reciprocal multiply that
// scales each channel to 0-255 into the output register.
// Reset clears all stage valid bits; data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises in the same cycle; a bubble in the output register
// lets the pipeline advance even while i_stall is high.
module hsv_to_rgb_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hsv2rgb_pkg::t_hsv  i_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output hsv2rgb_pkg::t_rgb  o_pixel
);
    import hsv2rgb_pkg::*;

    localparam int unsigned STAGES = 5;

    logic              w_en;
    logic [STAGES-1:0] r_vld;

    // stage 1
    logic             w_err1;
    logic [2:0]       w_sec1;
    logic [HUE_W-1:0] w_hm1;
    logic [HUE_W-1:0] w_tri_full1;
    logic             r_err1;
    logic [2:0]       r_sec1;
    logic [TRI_W-1:0] r_tri1;
    logic [PCT_W-1:0] r_s1;
    logic [PCT_W-1:0] r_v1;

    // stage 2
    logic              r_err2;
    logic [2:0]        r_sec2;
    logic [TRI_W-1:0]  r_tri2;
    logic [PROD_W-1:0] r_sv2;
    logic [PROD_W-1:0] r_v100_2;

    // stage 3
    logic              r_err3;
    logic [2:0]        r_sec3;
    logic [NUM_W-1:0]  r_c3;
    logic [NUM_W-1:0]  r_x3;
    logic [NUM_W-1:0]  r_m3;

    // stage 4
    logic              r_err4;
    logic [NUM_W-1:0]  n_rn4, n_gn4, n_bn4;
    logic [NUM_W-1:0]  r_rn4, r_gn4, r_bn4;

    // stage 5
    logic [PRODUCT_W-1:0] w_pr5, w_pg5, w_pb5;
    t_rgb                 n_out;
    t_rgb                 r_out;

    assign w_en    = !(r_vld[STAGES-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[STAGES-1];
    assign o_pixel = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // range check, sector and triangle weight
    always_comb begin
        w_err1 = (i_pixel.hue > HUE_W'(HUE_MAX))
              || (i_pixel.saturation > PCT_W'(PCT_MAX))
              || (i_pixel.brightness > PCT_W'(PCT_MAX));
        if (i_pixel.hue < HUE_W'(SECTOR_DEG)) begin
            w_sec1 = SEC_RED_GREEN;
        end else if (i_pixel.hue < HUE_W'(2 * SECTOR_DEG)) begin
            w_sec1 = SEC_GREEN_RED;
        end else if (i_pixel.hue < HUE_W'(3 * SECTOR_DEG)) begin
            w_sec1 = SEC_GREEN_BLUE;
        end else if (i_pixel.hue < HUE_W'(4 * SECTOR_DEG)) begin
            w_sec1 = SEC_BLUE_GREEN;
        end else if (i_pixel.hue < HUE_W'(5 * SECTOR_DEG)) begin
            w_sec1 = SEC_BLUE_RED;
        end else begin
            w_sec1 = SEC_RED_BLUE;
        end
        if (i_pixel.hue < HUE_W'(2 * SECTOR_DEG)) begin
            w_hm1 = i_pixel.hue;
        end else if (i_pixel.hue < HUE_W'(4 * SECTOR_DEG)) begin
            w_hm1 = i_pixel.hue - HUE_W'(2 * SECTOR_DEG);
        end else if (i_pixel.hue < HUE_W'(6 * SECTOR_DEG)) begin
            w_hm1 = i_pixel.hue - HUE_W'(4 * SECTOR_DEG);
        end else begin
            w_hm1 = i_pixel.hue - HUE_W'(6 * SECTOR_DEG);
        end
        if (w_hm1 >= HUE_W'(SECTOR_DEG)) begin
            w_tri_full1 = HUE_W'(2 * SECTOR_DEG) - w_hm1;
        end else begin
            w_tri_full1 = w_hm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err1 <= w_err1;
            r_sec1 <= w_sec1;
            r_tri1 <= w_tri_full1[TRI_W-1:0];
            r_s1   <= i_pixel.saturation;
            r_v1   <= i_pixel.brightness;
        end
    end

    // s*v and 100*v
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err2   <= r_err1;
            r_sec2   <= r_sec1;
            r_tri2   <= r_tri1;
            r_sv2    <= PROD_W'(r_s1) * PROD_W'(r_v1);
            r_v100_2 <= PROD_W'(r_v1) * PROD_W'(PCT_MAX);
        end
    end

    // chroma, secondary and offset numerators over 600000
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err3 <= r_err2;
            r_sec3 <= r_sec2;
            r_c3   <= NUM_W'(r_sv2) * NUM_W'(SECTOR_DEG);
            r_x3   <= NUM_W'(r_sv2) * NUM_W'(r_tri2);
            r_m3   <= NUM_W'(PROD_W'(r_v100_2 - r_sv2)) * NUM_W'(SECTOR_DEG);
        end
    end

    // route chroma and secondary by sector, add offset
    always_comb begin
        case (r_sec3)
            SEC_RED_GREEN: begin
                n_rn4 = r_c3 + r_m3; n_gn4 = r_x3 + r_m3; n_bn4 = r_m3;
            end
            SEC_GREEN_RED: begin
                n_rn4 = r_x3 + r_m3; n_gn4 = r_c3 + r_m3; n_bn4 = r_m3;
            end
            SEC_GREEN_BLUE: begin
                n_rn4 = r_m3; n_gn4 = r_c3 + r_m3; n_bn4 = r_x3 + r_m3;
            end
            SEC_BLUE_GREEN: begin
                n_rn4 = r_m3; n_gn4 = r_x3 + r_m3; n_bn4 = r_c3 + r_m3;
            end
            SEC_BLUE_RED: begin
                n_rn4 = r_x3 + r_m3; n_gn4 = r_m3; n_bn4 = r_c3 + r_m3;
            end
            default: begin
                n_rn4 = r_c3 + r_m3; n_gn4 = r_m3; n_bn4 = r_x3 + r_m3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_err4 <= r_err3;
            r_rn4  <= n_rn4;
            r_gn4  <= n_gn4;
            r_bn4  <= n_bn4;
        end
    end

    // scale to 0-255 by reciprocal multiply
    assign w_pr5 = PRODUCT_W'(r_rn4) * PRODUCT_W'(CHAN_MUL);
    assign w_pg5 = PRODUCT_W'(r_gn4) * PRODUCT_W'(CHAN_MUL);
    assign w_pb5 = PRODUCT_W'(r_bn4) * PRODUCT_W'(CHAN_MUL);

    always_comb begin
        if (r_err4) begin
            n_out.red   = '0;
            n_out.green = '0;
            n_out.blue  = '0;
        end else begin
            n_out.red   = w_pr5[DIV_SHIFT +: CHAN_W];
            n_out.green = w_pg5[DIV_SHIFT +: CHAN_W];
            n_out.blue  = w_pb5[DIV_SHIFT +: CHAN_W];
        end
        n_out.range_error = r_err4;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    a_sv_le_v100: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !r_err2 |-> r_sv2 <= r_v100_2)
        else $error("s*v exceeds 100*v on an in-range beat");

    a_num_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !r_err4 |-> (r_rn4 <= NUM_W'(DENOM)) && (r_gn4 <= NUM_W'(DENOM))
            && (r_bn4 <= NUM_W'(DENOM)))
        else $error("channel numerator above full scale");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel.range_error |-> (o_pixel.red == '0) && (o_pixel.green == '0)
            && (o_pixel.blue == '0))
        else $error("range error beat with nonzero channels");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld) && $stable(r_rn4) && $stable(r_c3))
        else $error("pipeline moved while stalled");

endmodule

>>> tb/tb.sv
// testbench for hsv_to_rgb_converter: directed table, random pixels and a predictor
`timescale 1ns / 1ps

module tb;
    import hsv2rgb_pkg::*;

    localparam int unsigned CHAN_FULL      = 255;
    localparam int unsigned DIR_N          = 25;
    localparam int unsigned RAND_N         = 1750;
    localparam int unsigned HOLD_AT        = 400;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned PAUSE_AT       = 1000;
    localparam int unsigned PIPE_CYCLES    = 12;
    localparam longint     TIMEOUT_NS      = 5_000_000;

    typedef struct packed {
        t_hsv px;
        t_rgb rgb;
        logic typed;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_hsv i_pixel;
    logic o_valid;
    logic i_stall;
    t_rgb o_pixel;

    t_rgb        rgb_expected [$];
    int unsigned pixels_sent;
    int unsigned error_count;

    t_dir_row dir_rows [DIR_N] = '{
        '{'{9'd0,   7'd0,   7'd0},   '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1},
        '{'{9'd0,   7'd0,   7'd100}, '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1},
        '{'{9'd0,   7'd100, 7'd100}, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1},
        '{'{9'd120, 7'd100, 7'd100}, '{8'd0,   8'd255, 8'd0,   1'b0}, 1'b1},
        '{'{9'd240, 7'd100, 7'd100}, '{8'd0,   8'd0,   8'd255, 1'b0}, 1'b1},
        '{'{9'd360, 7'd100, 7'd100}, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b1},
        '{'{9'd200, 7'd100, 7'd0},   '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1},
        '{'{9'd361, 7'd50,  7'd50},  '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1},
        '{'{9'd0,   7'd101, 7'd50},  '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1},
        '{'{9'd0,   7'd50,  7'd101}, '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1},
        '{'{9'd511, 7'd127, 7'd127}, '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1},
        '{'{9'd360, 7'd100, 7'd127}, '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1},
        '{'{9'd60,  7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd180, 7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd300, 7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd59,  7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd119, 7'd90,  7'd80},  '0, 1'b0},
        '{'{9'd179, 7'd70,  7'd60},  '0, 1'b0},
        '{'{9'd239, 7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd299, 7'd55,  7'd45},  '0, 1'b0},
        '{'{9'd359, 7'd100, 7'd100}, '0, 1'b0},
        '{'{9'd30,  7'd50,  7'd50},  '0, 1'b0},
        '{'{9'd90,  7'd75,  7'd25},  '0, 1'b0},
        '{'{9'd200, 7'd1,   7'd1},   '0, 1'b0},
        '{'{9'd330, 7'd37,  7'd83},  '0, 1'b0}
    };

    hsv_to_rgb_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CHAN_W-1:0] scale_channel(input int unsigned num);
        return CHAN_W'((CHAN_FULL * num) / DENOM);
    endfunction

    function automatic t_rgb predict_rgb(input t_hsv px);
        int unsigned h, s, v, hm, t, c, x, m, r, g, b;
        t_rgb res;
        res = '0;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        if (h > HUE_MAX || s > PCT_MAX || v > PCT_MAX) begin
            res.range_error = 1'b1;
            return res;
        end
        hm = h % (2 * SECTOR_DEG);
        t  = (hm >= SECTOR_DEG) ? (2 * SECTOR_DEG - hm) : hm;
        c  = s * v * SECTOR_DEG;
        x  = s * v * t;
        m  = (PCT_MAX * v - s * v) * SECTOR_DEG;
        if (h < SECTOR_DEG) begin
            r = c; g = x; b = 0;
        end else if (h < 2 * SECTOR_DEG) begin
            r = x; g = c; b = 0;
        end else if (h < 3 * SECTOR_DEG) begin
            r = 0; g = c; b = x;
        end else if (h < 4 * SECTOR_DEG) begin
            r = 0; g = x; b = c;
        end else if (h < 5 * SECTOR_DEG) begin
            r = x; g = 0; b = c;
        end else begin
            r = c; g = 0; b = x;
        end
        res.red   = scale_channel(r + m);
        res.green = scale_channel(g + m);
        res.blue  = scale_channel(b + m);
        return res;
    endfunction

    function automatic t_hsv random_pixel();
        t_hsv px;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 82) begin
            px.hue        = HUE_W'($urandom_range(0, HUE_MAX));
            px.saturation = PCT_W'($urandom_range(0, PCT_MAX));
            px.brightness = PCT_W'($urandom_range(0, PCT_MAX));
        end else if (roll < 92) begin
            // sector boundaries with full or random levels
            px.hue        = HUE_W'($urandom_range(0, 6) * SECTOR_DEG);
            px.saturation = $urandom_range(0, 1) ? PCT_W'(PCT_MAX)
                                                 : PCT_W'($urandom_range(0, PCT_MAX));
            px.brightness = $urandom_range(0, 1) ? PCT_W'(PCT_MAX)
                                                 : PCT_W'($urandom_range(0, PCT_MAX));
        end else begin
            px.hue        = HUE_W'($urandom);
            px.saturation = PCT_W'($urandom);
            px.brightness = PCT_W'($urandom);
        end
        return px;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_pixel(input t_hsv px, input t_rgb typed_rgb, input logic typed);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        rgb_expected.push_back(typed ? typed_rgb : predict_rgb(px));
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            i_valid <= 1'b0;
            i_pixel <= random_pixel();
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (rgb_expected.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] exp_val,
                               input logic [CHAN_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    initial begin
        int unsigned burst;
        int unsigned random_sent;
        bit          paused;
        pixels_sent = 0;
        error_count = 0;
        random_sent = 0;
        paused      = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_pixel <= '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].px, dir_rows[i].rgb, dir_rows[i].typed);
            idle_cycles($urandom_range(0, 2));
        end
        wait_drained();

        while (random_sent < RAND_N) begin
            burst = $urandom_range(1, 24);
            for (int unsigned k = 0; k < burst && random_sent < RAND_N; k++) begin
                send_pixel(random_pixel(), '0, 1'b0);
                random_sent++;
            end
            if (!paused && pixels_sent >= PAUSE_AT) begin
                wait_drained();
                paused = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 7));
            end
        end
        wait_drained();
        repeat (PIPE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int unsigned len;
        int unsigned mode;
        bit          held;
        held = 1'b0;
        i_stall <= 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        forever begin
            if (!held && pixels_sent >= HOLD_AT) begin
                // long hold-off so the pipeline fills and stalls its input
                held = 1'b1;
                for (int unsigned k = 0; k < HOLDOFF_CYCLES; k++) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            len  = $urandom_range(5, 60);
            mode = $urandom_range(0, 3);
            for (int unsigned k = 0; k < len; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 99) < 30);
                    2: i_stall <= ($urandom_range(0, 99) < 70);
                    default: i_stall <= (k % 4) < 2;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_rgb exp_rgb;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (rgb_expected.size() == 0) begin
                $error("unexpected output beat: %h", o_pixel);
                error_count++;
            end else begin
                exp_rgb = rgb_expected.pop_front();
                check_field("red", exp_rgb.red, o_pixel.red);
                check_field("green", exp_rgb.green, o_pixel.green);
                check_field("blue", exp_rgb.blue, o_pixel.blue);
                check_field("range_error", CHAN_W'(exp_rgb.range_error),
                            CHAN_W'(o_pixel.range_error));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> hsv_to_rgb_converter.f
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter.sv
tb/tb.sv
